### rtl/rc4_pkg.sv
// ---------------------------------------------------------------------------
// rc4_pkg
// Shared types and constants for the RC4 cipher block.
// ---------------------------------------------------------------------------
package rc4_pkg;

    localparam int PermSize = 256;
    localparam int ByteW    = 8;
    localparam int IdxW     = $clog2(PermSize);
    localparam int KeyLenW  = IdxW + 1;

    localparam logic [KeyLenW-1:0] KeyLenReset = KeyLenW'(16);

    typedef logic [ByteW-1:0] byte_t;
    typedef logic [IdxW-1:0]  idx_t;
    typedef logic [1:0]       op_t;

    // operation codes; out_kind reuses the same codes
    localparam op_t OP_KEY_WRITE = 2'd0;
    localparam op_t OP_SCHEDULE  = 2'd1;
    localparam op_t OP_CRYPT     = 2'd2;
    localparam op_t OP_UNUSED    = 2'd3;

    // permutation memory request
    typedef struct packed {
        logic  clear;
        logic  we;
        idx_t  waddr;
        byte_t wdata;
        idx_t  raddr;
    } perm_req_t;

endpackage

### rtl/rc4_if.sv
// ---------------------------------------------------------------------------
// rc4 channel interfaces
// Valid/ready channels for request items and result items.
// ---------------------------------------------------------------------------
interface rc4_in_if import rc4_pkg::*; ();
    logic  valid;
    logic  ready;
    op_t   operation;
    idx_t  key_index;
    byte_t data_in;
    logic  direction;
    logic  last_in;

    modport source (output valid, operation, key_index, data_in, direction, last_in,
                    input ready);
    modport sink   (input valid, operation, key_index, data_in, direction, last_in,
                    output ready);
endinterface

interface rc4_out_if import rc4_pkg::*; ();
    logic  valid;
    logic  ready;
    byte_t out_data;
    op_t   out_kind;
    logic  last_out;

    modport source (output valid, out_data, out_kind, last_out, input ready);
    modport sink   (input valid, out_data, out_kind, last_out, output ready);
endinterface

### rtl/rc4_perm_mem.sv
// ---------------------------------------------------------------------------
// rc4_perm_mem
// 256-entry permutation store, one write and one registered read per cycle.
// Entries not written since reset or the last clear read as their address.
// ---------------------------------------------------------------------------
module rc4_perm_mem import rc4_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  perm_req_t req,
    output byte_t     rdata
);

    byte_t               mem [PermSize];
    logic [PermSize-1:0] valid_reg;
    logic                hit_reg;
    byte_t               rdata_reg;
    idx_t                raddr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (req.clear)
            begin
                valid_reg <= '0;
            end
            else if (req.we)
            begin
                valid_reg[req.waddr] <= 1'b1;
            end
            hit_reg <= valid_reg[req.raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
        raddr_reg <= req.raddr;
    end

    // unwritten entry holds the identity value
    assign rdata = hit_reg ? rdata_reg : byte_t'(raddr_reg);

endmodule

### rtl/rc4_core.sv
// ---------------------------------------------------------------------------
// rc4_core
// Sequencer for key writes, key schedule and keystream generation. One shared
// byte adder serves the j and t index sums; the key store lives here.
// ---------------------------------------------------------------------------
module rc4_core import rc4_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    rc4_in_if.sink              din,
    rc4_out_if.source           dout,
    input  logic [KeyLenW-1:0]  key_length,
    output perm_req_t           enc_req,
    output perm_req_t           dec_req,
    input  byte_t               enc_rdata,
    input  byte_t               dec_rdata
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCH_CLR,
        ST_SCH_RD_I,
        ST_SCH_RD_J,
        ST_SCH_WR_I,
        ST_SCH_WR_J,
        ST_CRY_RD_I,
        ST_CRY_RD_J,
        ST_CRY_WR_I,
        ST_CRY_WR_J,
        ST_FINISH
    } state_t;

    state_t state_reg;

    byte_t key_mem [PermSize];
    byte_t key_rdata_reg;

    idx_t  n_reg;
    idx_t  kp_reg;
    byte_t j_reg;
    byte_t si_reg;
    byte_t sj_reg;
    byte_t t_reg;
    byte_t data_reg;
    op_t   kind_reg;
    logic  last_reg;
    logic  dir_reg;

    idx_t  enc_i_reg;
    byte_t enc_j_reg;
    idx_t  dec_i_reg;
    byte_t dec_j_reg;

    logic  out_valid_reg;
    byte_t out_data_reg;
    op_t   out_kind_reg;
    logic  out_last_reg;

    logic              accept;
    logic              sched;
    logic              out_load;
    byte_t             rsel;
    idx_t              ctx_i;
    byte_t             ctx_j;
    byte_t             add_a;
    byte_t             add_b;
    byte_t             add_c;
    byte_t             sum;
    byte_t             ks;
    logic [KeyLenW-1:0] len_eff;
    logic [KeyLenW-1:0] kp_inc;
    idx_t              kp_next;
    perm_req_t         req;

    assign din.ready = (state_reg == ST_IDLE);
    assign accept    = din.valid && din.ready;

    assign dout.valid    = out_valid_reg;
    assign dout.out_data = out_data_reg;
    assign dout.out_kind = out_kind_reg;
    assign dout.last_out = out_last_reg;

    assign out_load = (state_reg == ST_FINISH) && (!out_valid_reg || dout.ready);

    assign sched = (state_reg == ST_SCH_CLR) || (state_reg == ST_SCH_RD_I) ||
                   (state_reg == ST_SCH_RD_J) || (state_reg == ST_SCH_WR_I) ||
                   (state_reg == ST_SCH_WR_J);

    assign rsel  = dir_reg ? dec_rdata : enc_rdata;
    assign ctx_i = dir_reg ? dec_i_reg : enc_i_reg;
    assign ctx_j = dir_reg ? dec_j_reg : enc_j_reg;

    // key length clamped to 1..PermSize
    assign len_eff = (key_length == '0) ? KeyLenW'(1) :
                     (key_length > KeyLenW'(PermSize)) ? KeyLenW'(PermSize) : key_length;
    assign kp_inc  = {1'b0, kp_reg} + KeyLenW'(1);
    assign kp_next = (kp_inc >= len_eff) ? '0 : kp_inc[IdxW-1:0];

    // shared adder
    always_comb
    begin
        add_a = '0;
        add_b = '0;
        add_c = '0;
        case (state_reg)
            ST_SCH_RD_J:
            begin
                add_a = j_reg;
                add_b = rsel;
                add_c = key_rdata_reg;
            end
            ST_CRY_RD_J:
            begin
                add_a = ctx_j;
                add_b = rsel;
            end
            ST_CRY_WR_I:
            begin
                add_a = si_reg;
                add_b = rsel;
            end
            default:
            begin
                add_a = '0;
            end
        endcase
    end

    assign sum = add_a + add_b + add_c;

    // keystream byte; bypass entries rewritten around the read
    assign ks = (t_reg == j_reg) ? si_reg :
                (t_reg == byte_t'(ctx_i)) ? sj_reg : rsel;

    always_comb
    begin
        req = '0;
        case (state_reg)
            ST_SCH_CLR:
            begin
                req.clear = 1'b1;
            end
            ST_SCH_RD_I:
            begin
                req.raddr = n_reg;
            end
            ST_SCH_RD_J:
            begin
                req.raddr = idx_t'(sum);
            end
            ST_SCH_WR_I:
            begin
                req.we    = 1'b1;
                req.waddr = n_reg;
                req.wdata = rsel;
            end
            ST_SCH_WR_J:
            begin
                req.we    = 1'b1;
                req.waddr = idx_t'(j_reg);
                req.wdata = si_reg;
            end
            ST_CRY_RD_I:
            begin
                req.raddr = ctx_i;
            end
            ST_CRY_RD_J:
            begin
                req.raddr = idx_t'(sum);
            end
            ST_CRY_WR_I:
            begin
                req.we    = 1'b1;
                req.waddr = ctx_i;
                req.wdata = rsel;
                req.raddr = idx_t'(sum);
            end
            ST_CRY_WR_J:
            begin
                req.we    = 1'b1;
                req.waddr = idx_t'(j_reg);
                req.wdata = si_reg;
            end
            default:
            begin
                req.clear = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        enc_req    = req;
        dec_req    = req;
        enc_req.we = req.we && (sched || !dir_reg);
        dec_req.we = req.we && (sched || dir_reg);
    end

    always_ff @(posedge clk)
    begin
        if (accept && (din.operation == OP_KEY_WRITE))
        begin
            key_mem[din.key_index] <= din.data_in;
        end
        key_rdata_reg <= key_mem[kp_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            n_reg         <= '0;
            kp_reg        <= '0;
            j_reg         <= '0;
            si_reg        <= '0;
            sj_reg        <= '0;
            t_reg         <= '0;
            data_reg      <= '0;
            kind_reg      <= OP_KEY_WRITE;
            last_reg      <= 1'b0;
            dir_reg       <= 1'b0;
            enc_i_reg     <= idx_t'(1);
            enc_j_reg     <= '0;
            dec_i_reg     <= idx_t'(1);
            dec_j_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_kind_reg  <= OP_KEY_WRITE;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && dout.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (din.valid)
                    begin
                        kind_reg <= din.operation;
                        last_reg <= din.last_in;
                        case (din.operation)
                            OP_KEY_WRITE:
                            begin
                                data_reg  <= '0;
                                state_reg <= ST_FINISH;
                            end
                            OP_SCHEDULE:
                            begin
                                dir_reg   <= 1'b0;
                                n_reg     <= '0;
                                kp_reg    <= '0;
                                j_reg     <= '0;
                                state_reg <= ST_SCH_CLR;
                            end
                            OP_CRYPT:
                            begin
                                dir_reg   <= din.direction;
                                data_reg  <= din.data_in;
                                state_reg <= ST_CRY_RD_I;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_SCH_CLR:
                begin
                    state_reg <= ST_SCH_RD_I;
                end
                ST_SCH_RD_I:
                begin
                    state_reg <= ST_SCH_RD_J;
                end
                ST_SCH_RD_J:
                begin
                    si_reg    <= rsel;
                    j_reg     <= sum;
                    state_reg <= ST_SCH_WR_I;
                end
                ST_SCH_WR_I:
                begin
                    state_reg <= ST_SCH_WR_J;
                end
                ST_SCH_WR_J:
                begin
                    n_reg  <= n_reg + idx_t'(1);
                    kp_reg <= kp_next;
                    if (n_reg == idx_t'(PermSize - 1))
                    begin
                        enc_i_reg <= idx_t'(1);
                        enc_j_reg <= '0;
                        dec_i_reg <= idx_t'(1);
                        dec_j_reg <= '0;
                        data_reg  <= '0;
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        state_reg <= ST_SCH_RD_I;
                    end
                end
                ST_CRY_RD_I:
                begin
                    state_reg <= ST_CRY_RD_J;
                end
                ST_CRY_RD_J:
                begin
                    si_reg    <= rsel;
                    j_reg     <= sum;
                    state_reg <= ST_CRY_WR_I;
                end
                ST_CRY_WR_I:
                begin
                    sj_reg    <= rsel;
                    t_reg     <= sum;
                    state_reg <= ST_CRY_WR_J;
                end
                ST_CRY_WR_J:
                begin
                    data_reg <= data_reg ^ ks;
                    if (dir_reg)
                    begin
                        dec_i_reg <= dec_i_reg + idx_t'(1);
                        dec_j_reg <= j_reg;
                    end
                    else
                    begin
                        enc_i_reg <= enc_i_reg + idx_t'(1);
                        enc_j_reg <= j_reg;
                    end
                    state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (out_load)
                    begin
                        out_data_reg  <= data_reg;
                        out_kind_reg  <= kind_reg;
                        out_last_reg  <= last_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/rc4_stream_cipher.sv
// ---------------------------------------------------------------------------
// rc4_stream_cipher
// RC4 cipher with key store, key schedule and separate encrypt and decrypt
// contexts.
//
// din carries request items: key byte write, key schedule, or crypt one byte
// with the encrypt or decrypt context. dout carries one result item per
// request (none for the unused operation code). cfg_we/cfg_wdata set
// key_length, the number of key bytes used by the schedule.
// Each permutation memory has one read and one write port, so all index
// lookups and swaps are serialized through it:
//   key byte write: stored in the key store on accept, then the result.
//   crypt byte:     read S[i], read S[j], write S[i], write S[j], then result.
//   key schedule:   clear, then read i, read j, write i, write j per entry.
// din.ready is high only while the sequencer is idle. A finished result sits
// in the output register; the next item is accepted while it waits, and its
// own result holds in the sequencer until dout.ready frees the register.
// Reset restores identity permutations, index one and accumulator zero for
// both contexts, and key_length 16. Key store contents are undefined.
// ---------------------------------------------------------------------------
module rc4_stream_cipher import rc4_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    rc4_in_if.sink             din,
    rc4_out_if.source          dout,
    input  logic               cfg_we,
    input  logic [KeyLenW-1:0] cfg_wdata
);

    logic [KeyLenW-1:0] key_length_reg;
    perm_req_t          enc_req;
    perm_req_t          dec_req;
    byte_t              enc_rdata;
    byte_t              dec_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_length_reg <= KeyLenReset;
        end
        else if (cfg_we)
        begin
            key_length_reg <= cfg_wdata;
        end
    end

    rc4_perm_mem u_enc_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (enc_req),
        .rdata (enc_rdata)
    );

    rc4_perm_mem u_dec_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dec_req),
        .rdata (dec_rdata)
    );

    rc4_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .din        (din),
        .dout       (dout),
        .key_length (key_length_reg),
        .enc_req    (enc_req),
        .dec_req    (dec_req),
        .enc_rdata  (enc_rdata),
        .dec_rdata  (dec_rdata)
    );

    // a real request leaves the sequencer busy in the cycle after acceptance
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        din.valid && din.ready && (din.operation != OP_UNUSED) |=> !din.ready)
        else $error("sequencer ready right after a request");

    // unused code yields no result
    a_unused_silent: assert property (@(posedge clk) disable iff (!rst_n)
        din.valid && din.ready && (din.operation == OP_UNUSED) && !dout.valid
        |=> !dout.valid)
        else $error("result produced for unused operation");

    // key write result reaches an empty output through ST_FINISH and the output register
    a_key_latency: assert property (@(posedge clk) disable iff (!rst_n)
        din.valid && din.ready && (din.operation == OP_KEY_WRITE) && !dout.valid
        |=> ##1 dout.valid && (dout.out_kind == OP_KEY_WRITE))
        else $error("key write result missing");

    // results other than crypted bytes carry zero data
    a_crypt_zero_free: assert property (@(posedge clk) disable iff (!rst_n)
        dout.valid && (dout.out_kind != OP_CRYPT) |-> (dout.out_data == '0))
        else $error("nonzero data on a non-crypt result");

endmodule
